### rtl/core/emd_pkg.sv
package emd_pkg;

  // Result slots needed by one input byte: four held characters plus the byte itself.
  localparam int unsigned NumRes    = 5;
  localparam int unsigned HeldDepth = 4;
  localparam int unsigned EntCount  = 4;
  localparam int unsigned CntW      = 3;

  localparam logic [7:0] ChAmp   = 8'h26;  // '&'
  localparam logic [7:0] ChSemi  = 8'h3b;  // ';'
  localparam logic [7:0] ChUpA   = 8'h41;  // 'A'
  localparam logic [7:0] ChUpZ   = 8'h5a;  // 'Z'
  localparam logic [7:0] ChLt    = 8'h3c;  // '<'
  localparam logic [7:0] ChGt    = 8'h3e;  // '>'
  localparam logic [7:0] ChQuote = 8'h22;  // '"'

  // Entity names in lower case, padded with zero: amp, lt, gt, quot.
  localparam logic [7:0] EntName [EntCount][HeldDepth] = '{
    '{8'h61, 8'h6d, 8'h70, 8'h00},
    '{8'h6c, 8'h74, 8'h00, 8'h00},
    '{8'h67, 8'h74, 8'h00, 8'h00},
    '{8'h71, 8'h75, 8'h6f, 8'h74}
  };
  localparam logic [CntW-1:0] EntLen [EntCount] = '{3'd3, 3'd2, 3'd2, 3'd4};
  localparam logic [7:0] EntChar [EntCount] = '{ChAmp, ChLt, ChGt, ChQuote};

  // One result slot.
  typedef struct packed {
    logic [7:0] ch;
    logic       vld;
  } emd_res_t;

  // All results caused by one input byte.
  typedef struct packed {
    emd_res_t [NumRes-1:0] res;
    logic [CntW-1:0]       cnt;
    logic                  last;
  } emd_batch_t;

  // State update for the entity tracker.
  typedef struct packed {
    logic            in_entity;
    logic [CntW-1:0] held_count;
    logic            held_we;
  } emd_upd_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= ChUpA && c <= ChUpZ) r = c | 8'h20;
    return r;
  endfunction

endpackage

### rtl/core/emd_step.sv
module emd_step
  import emd_pkg::*;
(
  input  logic                  in_entity_i,
  input  logic [CntW-1:0]       held_count_i,
  input  logic [HeldDepth-1:0][7:0] held_chars_i,
  input  logic [7:0]            char_i,
  input  logic                  last_i,
  output emd_upd_t              upd_o,
  output emd_batch_t            batch_o
);

  logic       found;
  logic       ext;
  logic       close;
  logic [7:0] close_ch;
  logic       m;
  logic [7:0] lc;

  // Match the open name against the four entities, first candidate wins.
  always_comb begin
    lc       = to_lower(char_i);
    found    = 1'b0;
    ext      = 1'b0;
    close    = 1'b0;
    close_ch = '0;
    m        = 1'b0;
    for (int k = 0; k < EntCount; k++) begin
      m = (held_count_i <= EntLen[k]);
      for (int i = 0; i < HeldDepth; i++) begin
        if (CntW'(i) < held_count_i && to_lower(held_chars_i[i]) != EntName[k][i]) m = 1'b0;
      end
      if (in_entity_i && !found && m) begin
        if (held_count_i < EntLen[k] && lc == EntName[k][held_count_i[1:0]]) begin
          found = 1'b1;
          ext   = 1'b1;
        end else if (held_count_i == EntLen[k] && char_i == ChSemi) begin
          found    = 1'b1;
          close    = 1'b1;
          close_ch = EntChar[k];
        end
      end
    end
  end

  // Build the result list and the next tracker state.
  always_comb begin
    upd_o   = '0;
    batch_o = '0;
    batch_o.last = last_i;
    // Held characters first, then the current byte.
    for (int i = 0; i < HeldDepth; i++) begin
      batch_o.res[i].ch  = (CntW'(i) < held_count_i) ? held_chars_i[i] : char_i;
      batch_o.res[i].vld = 1'b1;
    end
    batch_o.res[NumRes-1].ch  = char_i;
    batch_o.res[NumRes-1].vld = 1'b1;

    if (ext) begin
      upd_o.held_we = 1'b1;
      if (last_i) begin
        batch_o.cnt = held_count_i + CntW'(1);
      end else begin
        upd_o.in_entity  = 1'b1;
        upd_o.held_count = held_count_i + CntW'(1);
      end
    end else if (close) begin
      batch_o.res[0].ch = close_ch;
      batch_o.cnt       = CntW'(1);
    end else begin
      // Failed match or plain byte: flush held name, then handle the byte.
      batch_o.cnt = held_count_i + CntW'(char_i != ChAmp);
      if (char_i == ChAmp && !last_i) upd_o.in_entity = 1'b1;
    end

    // An empty end marker when the final byte caused nothing.
    if (last_i && batch_o.cnt == '0) begin
      batch_o.res[0] = '0;
      batch_o.cnt    = CntW'(1);
    end
  end

endmodule

### rtl/core/emd_obuf.sv
module emd_obuf
  import emd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  emd_batch_t batch_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic       can_load_o,
  output logic [CntW-1:0] rem_o,
  output logic [7:0] char_out_o,
  output logic       char_valid_o,
  output logic       last_out_o
);

  emd_res_t [NumRes-1:0] res_q, res_d;
  logic [CntW-1:0]       rem_q, rem_d;
  logic                  last_q, last_d;
  logic                  pop;

  assign out_valid_o  = (rem_q != '0);
  assign pop          = out_valid_o && out_ready_i;
  assign can_load_o   = (rem_q == '0) || (rem_q == CntW'(1) && out_ready_i);
  assign rem_o        = rem_q;
  assign char_out_o   = res_q[0].ch;
  assign char_valid_o = res_q[0].vld;
  assign last_out_o   = last_q && (rem_q == CntW'(1));

  // Load a new batch, or shift the head out on each transfer.
  always_comb begin
    res_d  = res_q;
    rem_d  = rem_q;
    last_d = last_q;
    if (load_i) begin
      res_d  = batch_i.res;
      rem_d  = batch_i.cnt;
      last_d = batch_i.last;
    end else if (pop) begin
      for (int i = 0; i < NumRes - 1; i++) res_d[i] = res_q[i+1];
      rem_d = rem_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      last_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

### rtl/core/entity_markup_decoder.sv
// Byte-stream decoder for the entities &amp; &lt; &gt; &quot; (names matched
// without regard to case). One byte is taken per cycle; each accepted byte is
// decoded in the same cycle into a result buffer, and its first result is
// offered in the next cycle. The buffer drains one result per cycle. Most bytes
// yield zero or one result, so the stream moves at one byte per cycle. A failed
// entity match, or a final byte that flushes a held name, yields up to five
// results (held name characters plus the byte); the input then waits until the
// buffer is down to its last result, stalling while the extra results drain.
// The input also stalls whenever the receiver holds off while a result is
// still waiting.
module entity_markup_decoder
  import emd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       last_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] char_out_o,
  output logic       char_valid_o,
  output logic       last_out_o
);

  logic                       in_entity_q;
  logic [CntW-1:0]            held_count_q;
  logic [HeldDepth-1:0][7:0]  held_chars_q;
  emd_upd_t                   upd;
  emd_batch_t                 batch;
  logic                       accept;
  logic [CntW-1:0]            rem;

  assign accept = in_valid_i && in_ready_o;

  emd_step u_step (
    .in_entity_i  (in_entity_q),
    .held_count_i (held_count_q),
    .held_chars_i (held_chars_q),
    .char_i       (char_in_i),
    .last_i       (last_in_i),
    .upd_o        (upd),
    .batch_o      (batch)
  );

  emd_obuf u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .batch_i      (batch),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .can_load_o   (in_ready_o),
    .rem_o        (rem),
    .char_out_o   (char_out_o),
    .char_valid_o (char_valid_o),
    .last_out_o   (last_out_o)
  );

  // Entity tracker state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_entity_q  <= 1'b0;
      held_count_q <= '0;
    end else if (accept) begin
      in_entity_q  <= upd.in_entity;
      held_count_q <= upd.held_count;
    end
  end

  // Held name characters, written at the next free slot.
  always_ff @(posedge clk_i) begin
    if (accept && upd.held_we) held_chars_q[held_count_q[1:0]] <= char_in_i;
  end

`ifndef NO_ASSERTIONS
  a_held_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_entity_q |-> held_count_q == '0)
    else $error("held characters present outside an entity");

  a_held_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_count_q <= CntW'(HeldDepth))
    else $error("held count beyond depth");

  a_rem_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem <= CntW'(NumRes))
    else $error("result buffer count beyond capacity");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (rem == '0 || (rem == CntW'(1) && out_ready_i)))
    else $error("input taken while results still pending");
`endif

endmodule
